FILE: hdl/bpcd_pkg.sv
// Shared types and constants for the block patch command decoder.
`timescale 1ns / 1ps

package bpcd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int BLEN_W      = 16;
   localparam int CURSOR_W    = 17;
   localparam int END_W       = 18;
   localparam int MAG_W       = 31;
   localparam int DVD_W       = 32;
   localparam int DIV_CNT_W   = 5;
   localparam int STATUS_W    = 3;
   localparam int KIND_W      = 2;
   localparam int PHASE_W     = 3;
   localparam int ARGS_W      = 40;   // argument bytes held before the last one arrives
   localparam int RSP_DATA_W  = 72;

   localparam logic [BLEN_W-1:0]   BLOCK_LENGTH_RESET = 16'd4096;
   localparam logic [CURSOR_W-1:0] CURSOR_MAX         = 17'h1FFFF;
   localparam logic [LEN_W-1:0]    DEST_MAX           = 16'hFFFF;

   localparam logic [KIND_W-1:0] KIND_COPY  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIFF  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXTRA = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CROSS    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NEGATIVE = 3'd4;

   localparam logic [PHASE_W-1:0] PHASE_TYPE       = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_EXTRA_LAST = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_OFFS_LAST  = 3'd6;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV_MAG,
      S_DIV_CUR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                 done;
      logic [DVD_W-1:0]     quotient;
      logic [BLEN_W-1:0]    remainder;
   } div_res_type;

endpackage

FILE: hdl/block_patch_command_decoder_unit.sv
// Top level: control-stream command decoder for a block-wise delta patch.
`timescale 1ns / 1ps
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+--------------------------------------------
//  req      | in  | req_tvalid & req_tready| tdata: ctrl_byte; tuser: block_start
//  rsp      | out | rsp_tvalid & rsp_tready| tuser: op_kind; tdata: run_length,
//           |     |                        |  old_block, src_offset, dest_offset, status
//  csr      | in  | csr_wr_en              | csr_wr_data: block_length
//
//  Argument bytes are gathered until the last one arrives. A command's last byte starts the shared
//  32-step divider: copy/diff with a non-negative offset run it twice (offset, then
//  cursor); extra and negative offsets run it once. Unknown type bytes answer at
//  once: rsp_tvalid rises in the cycle after the type byte's transfer.
//  Reset (synchronous) clears parse state, cursor, error latch, block_length=4096.
//  req_tready is low while dividing, and also while a result waits un-taken.
//
module block_patch_command_decoder_unit
   import bpcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request: byte stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] ctrl_byte
   input  logic                  req_tuser,   // [0] block_start
   // response: one transfer per command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [15:0] run_length, [31:16] old_block,
                                              // [47:32] src_offset, [63:48] dest_offset,
                                              // [66:64] status, [71:67] zero
   output logic [KIND_W-1:0]     rsp_tuser,   // [1:0] op_kind
   // configuration
   input  logic                  csr_wr_en,
   input  logic [BLEN_W-1:0]     csr_wr_data
);

   state_type             state_ff, state_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [ARGS_W-1:0]     args_ff, args_in;
   logic [CURSOR_W-1:0]   cursor_ff, cursor_in;
   logic [STATUS_W-1:0]   err_ff, err_in;
   logic [BLEN_W-1:0]     blen_ff, blen_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  neg_ff, neg_in;
   logic [LEN_W-1:0]      oblk_ff, oblk_in;
   logic [BLEN_W-1:0]     ooff_ff, ooff_in;
   logic [BLEN_W-1:0]     curmod_ff, curmod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [LEN_W-1:0]      rsp_oblk_ff, rsp_oblk_in;
   logic [BLEN_W-1:0]     rsp_ooff_ff, rsp_ooff_in;
   logic [LEN_W-1:0]      rsp_dest_ff, rsp_dest_in;
   logic [STATUS_W-1:0]   rsp_st_ff, rsp_st_in;

   logic                  div_start;
   logic [DVD_W-1:0]      div_dividend;
   div_res_type           div_res;

   logic [BLEN_W-1:0]     blen_eff;
   logic                  out_free;
   logic                  take;
   logic [PHASE_W-1:0]    phase_eff;
   logic [CURSOR_W-1:0]   cursor_eff;
   logic [STATUS_W-1:0]   err_eff;
   logic                  last_byte;
   logic [LEN_W-1:0]      len_live;
   logic [MAG_W-1:0]      mag_live;
   logic                  neg_live;
   logic [END_W-1:0]      run_end;
   logic [BLEN_W:0]       mod_sum;
   logic [STATUS_W-1:0]   fresh;
   logic [LEN_W-1:0]      dest_sat;

   bpcd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (blen_eff),
      .res      (div_res)
   );

   assign blen_eff   = (blen_ff == '0) ? BLEN_W'(1) : blen_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign take       = req_tvalid && req_tready;

   // block start clears cursor, latch and phase before the byte is parsed
   assign phase_eff  = req_tuser ? PHASE_TYPE : phase_ff;
   assign cursor_eff = req_tuser ? '0 : cursor_ff;
   assign err_eff    = req_tuser ? ST_OK : err_ff;

   assign last_byte = (phase_eff != PHASE_TYPE) &&
                      (((kind_ff == KIND_EXTRA) && (phase_eff == PHASE_EXTRA_LAST)) ||
                       ((kind_ff != KIND_EXTRA) && (phase_eff == PHASE_OFFS_LAST)));

   // length and offset with the arriving byte merged in
   assign len_live = (kind_ff == KIND_EXTRA) ? {req_tdata, args_ff[7:0]} : args_ff[15:0];
   assign mag_live = {req_tdata[6:0], args_ff[39:16]};
   assign neg_live = req_tdata[7] && (mag_live != '0);

   // cursor-based checks, used in S_FINISH
   assign run_end  = END_W'(cursor_ff) + END_W'(len_ff);
   assign mod_sum  = {1'b0, curmod_ff} + {1'b0, len_ff};
   assign dest_sat = (cursor_ff > CURSOR_W'(DEST_MAX)) ? DEST_MAX : cursor_ff[LEN_W-1:0];

   always_comb begin
      // run crosses when (cursor mod bl) + len exceeds bl
      if ((len_ff != '0) && (mod_sum > {1'b0, blen_eff})) begin
         fresh = ST_CROSS;
      end else if (run_end > END_W'(blen_eff)) begin
         fresh = ST_PAST_END;
      end else if (neg_ff) begin
         fresh = ST_NEGATIVE;
      end else begin
         fresh = ST_OK;
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      args_in      = args_ff;
      cursor_in    = cursor_ff;
      err_in       = err_ff;
      blen_in      = csr_wr_en ? csr_wr_data : blen_ff;
      len_in       = len_ff;
      neg_in       = neg_ff;
      oblk_in      = oblk_ff;
      ooff_in      = ooff_ff;
      curmod_in    = curmod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_oblk_in  = rsp_oblk_ff;
      rsp_ooff_in  = rsp_ooff_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_st_in    = rsp_st_ff;
      div_start    = 1'b0;
      div_dividend = {15'd0, cursor_ff};

      case (state_ff)
         S_IDLE: begin
            if (take) begin
               cursor_in = cursor_eff;
               err_in    = err_eff;
               if (phase_eff == PHASE_TYPE) begin
                  if (req_tdata > BYTE_W'(KIND_EXTRA)) begin
                     // unknown type: answer now, cursor holds
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_COPY;
                     rsp_len_in   = '0;
                     rsp_oblk_in  = '0;
                     rsp_ooff_in  = '0;
                     rsp_dest_in  = (cursor_eff > CURSOR_W'(DEST_MAX)) ?
                                    DEST_MAX : cursor_eff[LEN_W-1:0];
                     rsp_st_in    = (err_eff == ST_OK) ? ST_UNKNOWN : err_eff;
                     err_in       = rsp_st_in;
                     phase_in     = PHASE_TYPE;
                  end else begin
                     kind_in  = req_tdata[KIND_W-1:0];
                     args_in  = '0;
                     phase_in = PHASE_W'(1);
                  end
               end else if (last_byte) begin
                  phase_in = PHASE_TYPE;
                  len_in   = len_live;
                  neg_in   = (kind_ff != KIND_EXTRA) && neg_live;
                  div_start = 1'b1;
                  if ((kind_ff != KIND_EXTRA) && !neg_live) begin
                     div_dividend = {1'b0, mag_live};
                     state_in     = S_DIV_MAG;
                  end else begin
                     oblk_in  = '0;
                     ooff_in  = '0;
                     state_in = S_DIV_CUR;
                  end
               end else begin
                  case (phase_eff)
                     3'd1:    args_in[7:0]   = req_tdata;
                     3'd2:    args_in[15:8]  = req_tdata;
                     3'd3:    args_in[23:16] = req_tdata;
                     3'd4:    args_in[31:24] = req_tdata;
                     3'd5:    args_in[39:32] = req_tdata;
                     default: args_in        = args_ff;
                  endcase
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         S_DIV_MAG: begin
            if (div_res.done) begin
               oblk_in   = div_res.quotient[LEN_W-1:0];
               ooff_in   = div_res.remainder;
               div_start = 1'b1;
               state_in  = S_DIV_CUR;
            end
         end
         S_DIV_CUR: begin
            if (div_res.done) begin
               curmod_in = div_res.remainder;
               state_in  = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_len_in   = len_ff;
               rsp_oblk_in  = oblk_ff;
               rsp_ooff_in  = ooff_ff;
               rsp_dest_in  = dest_sat;
               rsp_st_in    = (err_ff == ST_OK) ? fresh : err_ff;
               err_in       = rsp_st_in;
               cursor_in    = (run_end > END_W'(CURSOR_MAX)) ?
                              CURSOR_MAX : run_end[CURSOR_W-1:0];
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      args_ff     <= args_in;
      len_ff      <= len_in;
      oblk_ff     <= oblk_in;
      ooff_ff     <= ooff_in;
      curmod_ff   <= curmod_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_oblk_ff <= rsp_oblk_in;
      rsp_ooff_ff <= rsp_ooff_in;
      rsp_dest_ff <= rsp_dest_in;
      rsp_st_ff   <= rsp_st_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PHASE_TYPE;
         kind_ff      <= KIND_COPY;
         cursor_ff    <= '0;
         err_ff       <= ST_OK;
         blen_ff      <= BLOCK_LENGTH_RESET;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         cursor_ff    <= cursor_in;
         err_ff       <= err_in;
         blen_ff      <= blen_in;
         neg_ff       <= neg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'd0, rsp_st_ff, rsp_dest_ff, rsp_ooff_ff, rsp_oblk_ff, rsp_len_ff};

endmodule

FILE: hdl/bpcd_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bpcd_div
   import bpcd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DVD_W-1:0]    dividend,
   input  logic [BLEN_W-1:0]   divisor,
   output div_res_type         res
);

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [BLEN_W-1:0]    rem_ff, rem_in;
   logic [BLEN_W-1:0]    dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [BLEN_W:0]      trial;
   logic [BLEN_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits 16 bits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[BLEN_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[BLEN_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done      = done_ff;
   assign res.quotient  = quo_ff;
   assign res.remainder = rem_ff;

endmodule

FILE: hdl/bpcd_checker.sv
// Port-level checks for the command decoder, bound to the top level.
`timescale 1ns / 1ps

module bpcd_checker
   import bpcd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [KIND_W-1:0]     rsp_tuser
);

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // extra carries no old-image position
   a_extra_no_old: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_EXTRA) |-> (rsp_tdata[47:16] == '0))
      else $error("extra with old block/offset");

   a_codes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser != 2'd3) && (rsp_tdata[66:64] <= ST_NEGATIVE) &&
                     (rsp_tdata[71:67] == '0))
      else $error("bad kind or status code");

endmodule

bind block_patch_command_decoder_unit bpcd_checker u_bpcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: tb/sv/testbench.sv
// Self-checking bench for the block patch command decoder: byte stream in, command records out.
`timescale 1ns / 1ps

module testbench;
   import bpcd_pkg::*;

   // One decoded command as it should leave the rsp channel.
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [LEN_W-1:0]    run_len;
      logic [LEN_W-1:0]    old_blk;
      logic [LEN_W-1:0]    old_off;
      logic [LEN_W-1:0]    dest;
      logic [STATUS_W-1:0] status;
   } cmd_result_type;

   // One row of the directed table. Rows with pin set carry a hand-written
   // record that replaces the predicted one.
   typedef struct {
      logic [7:0]     b;
      logic           s;
      bit             pin;
      cmd_result_type want;
   } stim_row_type;

   localparam cmd_result_type NO_RESULT       = '0;
   localparam int             NUM_PHASES      = 8;
   localparam int             BYTES_PER_PHASE = 180;
   localparam int             SETTLE_CYCLES   = 80;   // a bit over the two-division latency
   localparam int             NUM_ROWS        = 25;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_wr_en;
   logic [BLEN_W-1:0]     csr_wr_data;

   // Predicted decoder state, advanced on every req transfer.
   logic [BLEN_W-1:0]   pred_blen;
   logic [PHASE_W-1:0]  pred_phase;
   logic [KIND_W-1:0]   pred_kind;
   logic [47:0]         pred_args;
   logic [CURSOR_W-1:0] pred_cursor;
   logic [STATUS_W-1:0] pred_latch;

   cmd_result_type expected_results[$];
   int             mismatches;

   // Stimulus side knobs: 0 means no idling, N means a burst starts 1 time in N.
   int             req_gap_rate;
   int             rsp_stall_rate;
   int             rsp_hold;
   int             bytes_sent;
   logic [BLEN_W-1:0] stim_blen;
   bit             row_pinned;
   cmd_result_type row_want;

   stim_row_type   directed_rows[NUM_ROWS];
   logic [BLEN_W-1:0] phase_blen[NUM_PHASES];

   block_patch_command_decoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: far beyond the slowest legal run (every command dividing twice,
   // worst gaps and stalls on every transfer).
   initial begin
      #(64'd10_000_000);
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic logic [LEN_W-1:0] clip_dest(input int unsigned c);
      return (c > 32'(DEST_MAX)) ? DEST_MAX : LEN_W'(c);
   endfunction

   // Error latch: first error since the last block start wins.
   function automatic logic [STATUS_W-1:0] latch_status(input logic [STATUS_W-1:0] fresh);
      if (pred_latch == ST_OK)
         pred_latch = fresh;
      return pred_latch;
   endfunction

   // Advance the predicted parser by one control byte; a finished command or
   // an unknown type byte queues one expected record.
   task automatic predict_transfer(input logic [7:0] b, input logic s);
      cmd_result_type r;
      int unsigned divisor, len, mag, c, fin;
      logic neg;
      logic [STATUS_W-1:0] fresh;
      divisor = (pred_blen == '0) ? 1 : 32'(pred_blen);   // zero length acts as one
      neg     = 1'b0;
      fresh   = ST_OK;
      r       = NO_RESULT;
      // block start clears cursor and latch and forces a type byte
      if (s) begin
         pred_cursor = '0;
         pred_latch  = ST_OK;
         pred_phase  = PHASE_TYPE;
      end
      if (pred_phase == PHASE_TYPE) begin
         if (b > 8'(KIND_EXTRA)) begin
            // unknown type answers at once, cursor stays
            r.kind   = KIND_COPY;
            r.dest   = clip_dest(32'(pred_cursor));
            r.status = latch_status(ST_UNKNOWN);
            expected_results.push_back(r);
         end else begin
            pred_kind  = b[KIND_W-1:0];
            pred_args  = '0;
            pred_phase = PHASE_TYPE + 3'd1;
         end
      end else begin
         pred_args = pred_args | (48'(b) << (8 * (pred_phase - 3'd1)));
         if ((pred_kind == KIND_EXTRA && pred_phase < PHASE_EXTRA_LAST) ||
             (pred_kind != KIND_EXTRA && pred_phase < PHASE_OFFS_LAST)) begin
            pred_phase = pred_phase + 3'd1;
         end else begin
            pred_phase = PHASE_TYPE;
            len        = 32'(pred_args[15:0]);
            r.kind     = pred_kind;
            r.run_len  = pred_args[15:0];
            if (pred_kind != KIND_EXTRA) begin
               // sign-magnitude offset, sign in bit 47; minus zero is zero
               mag = 32'(pred_args[46:16]);
               neg = pred_args[47] && (mag != 0);
               if (!neg) begin
                  r.old_blk = LEN_W'(mag / divisor);
                  r.old_off = LEN_W'(mag % divisor);
               end
            end
            c   = 32'(pred_cursor);
            fin = c + len;
            if (len != 0 && ((fin - 1) / divisor) != (c / divisor))
               fresh = ST_CROSS;
            else if (fin > divisor)
               fresh = ST_PAST_END;
            else if (neg)
               fresh = ST_NEGATIVE;
            pred_cursor = (fin > 32'(CURSOR_MAX)) ? CURSOR_MAX : CURSOR_W'(fin);
            r.dest      = clip_dest(c);
            r.status    = latch_status(fresh);
            expected_results.push_back(r);
         end
      end
   endtask

   // Scoreboard: everything sampled at the rising edge. Response check comes
   // before the prediction of a byte taken on the same edge.
   always @(posedge clock) begin : scoreboard
      cmd_result_type want;
      int depth;
      if (reset) begin
         pred_blen   = BLOCK_LENGTH_RESET;
         pred_phase  = PHASE_TYPE;
         pred_kind   = KIND_COPY;
         pred_args   = '0;
         pred_cursor = '0;
         pred_latch  = ST_OK;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            pred_blen = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with none pending, dest_offset",
                               32'(rsp_tdata[63:48]), 32'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.kind)
                  report_mismatch("op_kind", 32'(rsp_tuser), 32'(want.kind));
               if (rsp_tdata[15:0] != want.run_len)
                  report_mismatch("run_length", 32'(rsp_tdata[15:0]), 32'(want.run_len));
               if (rsp_tdata[31:16] != want.old_blk)
                  report_mismatch("old_block", 32'(rsp_tdata[31:16]), 32'(want.old_blk));
               if (rsp_tdata[47:32] != want.old_off)
                  report_mismatch("src_offset", 32'(rsp_tdata[47:32]), 32'(want.old_off));
               if (rsp_tdata[63:48] != want.dest)
                  report_mismatch("dest_offset", 32'(rsp_tdata[63:48]), 32'(want.dest));
               if (rsp_tdata[66:64] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[66:64]), 32'(want.status));
               if (rsp_tdata[71:67] != '0)
                  report_mismatch("tdata pad", 32'(rsp_tdata[71:67]), 32'd0);
            end
         end
         if (req_tvalid && req_tready) begin
            depth = expected_results.size();
            predict_transfer(req_tdata, req_tuser);
            // pinned table row: the typed-in record stands instead
            if (row_pinned) begin
               if (expected_results.size() > depth)
                  void'(expected_results.pop_back());
               expected_results.push_back(row_want);
            end
         end
      end
   end

   // Receiver: random stall bursts, changed at the falling edge.
   initial begin
      rsp_tready = 1'b0;
      rsp_hold   = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready = 1'b0;
         end else if (rsp_stall_rate != 0 && $urandom_range(rsp_stall_rate - 1) == 0) begin
            rsp_hold   = $urandom_range(1, 11) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   function automatic int pick_idle_rate();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 3;
         2:       return 6;
         default: return 12;
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      int unsigned bound;
      bound = (stim_blen == '0) ? 1 : 32'(stim_blen);
      case ($urandom_range(9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'($urandom);
         3, 4:    return 16'($urandom_range(0, bound / 8 + 1));
         default: return 16'($urandom_range(0, bound));
      endcase
   endfunction

   function automatic logic [31:0] pick_offset();
      case ($urandom_range(11))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;   // minus zero
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h7FFF_FFFF;
         4, 5:    return {1'b1, 31'($urandom)};
         6, 7:    return 32'($urandom_range(0, 3 * 65536));
         default: return {1'b0, 31'($urandom)};
      endcase
   endfunction

   // Present one byte at the falling edge and hold it until the transfer.
   // Returns at the falling edge after the transfer, valid still high.
   task automatic send_byte(input logic [7:0] b, input logic s, input bit pin = 1'b0,
                            input cmd_result_type want = NO_RESULT);
      if (req_gap_rate != 0 && $urandom_range(req_gap_rate - 1) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = s;
      row_pinned = pin;
      row_want   = want;
      do
         @(posedge clock);
      while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Mostly well-formed commands with random fields, some unknown types,
   // some loose noise bytes, and now and then a block start that cuts a
   // command short.
   task automatic send_random_command();
      int pick;
      logic s;
      logic [1:0] kind;
      logic [15:0] len;
      logic [31:0] off;
      pick = $urandom_range(99);
      s    = ($urandom_range(7) == 0);
      if (pick < 8) begin
         send_byte(8'($urandom_range(3, 255)), s);
      end else if (pick < 16) begin
         repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(15) == 0);
      end else begin
         kind = (pick < 40) ? KIND_EXTRA : (($urandom_range(1) == 0) ? KIND_COPY : KIND_DIFF);
         len  = pick_length();
         off  = pick_offset();
         send_byte(8'(kind), s);
         send_byte(len[7:0], $urandom_range(29) == 0);
         send_byte(len[15:8], 1'b0);
         if (kind != KIND_EXTRA) begin
            for (int i = 0; i < 4; i++)
               send_byte(off[8*i +: 8], i == 1 && $urandom_range(29) == 0);
         end
      end
   endtask

   // Idle the sender until every record is back, then let the decoder settle.
   task automatic drain_and_settle();
      req_tvalid = 1'b0;
      row_pinned = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      mismatches     = 0;
      bytes_sent     = 0;
      row_pinned     = 1'b0;
      row_want       = NO_RESULT;
      req_gap_rate   = 4;
      rsp_stall_rate = 4;
      stim_blen      = BLOCK_LENGTH_RESET;

      // Directed table, block length still 4096 from reset.
      directed_rows = '{
         // unknown type on a block start
         '{8'hFF, 1'b1, 1'b1, '{KIND_COPY, 16'h0000, 16'h0000, 16'h0000, 16'h0000, ST_UNKNOWN}},
         // diff, length 4096, largest positive offset: fills the block exactly
         '{8'h01, 1'b1, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h10, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'h7F, 1'b0, 1'b1, '{KIND_DIFF, 16'h1000, 16'hFFFF, 16'h0FFF, 16'h0000, ST_OK}},
         // extra of one byte with the cursor at the block end
         '{8'h02, 1'b0, 1'b0, NO_RESULT},
         '{8'h01, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b1, '{KIND_EXTRA, 16'h0001, 16'h0000, 16'h0000, 16'h1000,
                               ST_PAST_END}},
         // new block, copy of 65535 bytes from minus zero: crosses the block
         '{8'h00, 1'b1, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h80, 1'b0, 1'b1, '{KIND_COPY, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, ST_CROSS}},
         // new block, empty diff with the most negative offset
         '{8'h01, 1'b1, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'h00, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b0, NO_RESULT},
         '{8'hFF, 1'b0, 1'b1, '{KIND_DIFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               ST_NEGATIVE}}
      };

      // Block lengths per random phase: both extremes, zero, odd and round sizes.
      phase_blen = '{16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd256, 16'($urandom_range(1, 65535)),
                     16'd100, BLOCK_LENGTH_RESET};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].b, directed_rows[i].s, directed_rows[i].pin,
                   directed_rows[i].want);

      for (int p = 0; p < NUM_PHASES; p++) begin
         // register write only with the decoder idle and nothing pending
         drain_and_settle();
         stim_blen   = phase_blen[p];
         csr_wr_data = stim_blen;
         csr_wr_en   = 1'b1;
         @(negedge clock);
         csr_wr_en   = 1'b0;
         // the closing phase runs with no gaps and no stalls
         req_gap_rate   = (p == NUM_PHASES - 1) ? 0 : pick_idle_rate();
         rsp_stall_rate = (p == NUM_PHASES - 1) ? 0 : pick_idle_rate();
         bytes_sent     = 0;
         while (bytes_sent < BYTES_PER_PHASE)
            send_random_command();
         // finish any open command so the next write lands between commands
         while (pred_phase != PHASE_TYPE)
            send_byte(8'($urandom), 1'b0);
      end

      drain_and_settle();
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
